### rtl/core/utf8s_pkg.sv
package utf8s_pkg;

    localparam logic [7:0] REPL_BYTE = 8'd63;   // '?'

    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    localparam int MAX_RES   = 4;
    localparam int QDEPTH    = 8;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int RESN_W    = $clog2(MAX_RES + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       replaced;
        logic       run_end;
        logic       string_end;
    } res_t;

    // up to four results made by one input word
    typedef struct packed {
        res_t [MAX_RES-1:0] item;
        logic [RESN_W-1:0]  n;
    } res_group_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b[7:5] == LEAD2_TAG) begin
            len = 3'd2;
        end else if (b[7:4] == LEAD3_TAG) begin
            len = 3'd3;
        end else if (b[7:3] == LEAD4_TAG) begin
            len = 3'd4;
        end
        return len;
    endfunction

endpackage

### rtl/core/utf8s_decode.sv
module utf8s_decode (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output utf8s_pkg::res_group_t group
);
    import utf8s_pkg::*;

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] held_count_reg, held_count_next;
    logic [2:0] seq_len_reg, seq_len_next;

    logic       is_cont;
    logic       fresh;
    logic [2:0] len;

    assign is_cont = (in_byte[7:6] == CONT_TAG);
    assign len     = lead_length(in_byte);

    always_comb begin
        logic [RESN_W-1:0] n;
        res_t              r [MAX_RES];
        for (int k = 0; k < MAX_RES; k++) begin
            r[k] = '0;
        end
        n               = '0;
        fresh           = 1'b1;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;

        if (held_count_reg != 2'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if ({1'b0, held_count_reg} + 3'd1 >= seq_len_reg) begin
                    // sequence complete: release it unchanged
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < held_count_reg) begin
                            r[k].data = held_reg[k];
                        end
                    end
                    n = RESN_W'(held_count_reg);
                    r[n[1:0]].data = in_byte;
                    n = n + RESN_W'(1);
                    held_count_next = 2'd0;
                    seq_len_next    = 3'd0;
                end else if (in_last) begin
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < held_count_reg) begin
                            r[k].data     = REPL_BYTE;
                            r[k].replaced = 1'b1;
                        end
                    end
                    n = RESN_W'(held_count_reg);
                    r[n[1:0]].data     = REPL_BYTE;
                    r[n[1:0]].replaced = 1'b1;
                    n = n + RESN_W'(1);
                    held_count_next = 2'd0;
                    seq_len_next    = 3'd0;
                end else begin
                    // absorb continuation
                    held_next[held_count_reg] = in_byte;
                    held_count_next = held_count_reg + 2'd1;
                end
            end else begin
                // broken sequence: replace everything held
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < held_count_reg) begin
                        r[k].data     = REPL_BYTE;
                        r[k].replaced = 1'b1;
                    end
                end
                n = RESN_W'(held_count_reg);
                held_count_next = 2'd0;
                seq_len_next    = 3'd0;
            end
        end

        if (fresh) begin
            if (!in_byte[7]) begin
                r[n[1:0]].data = in_byte;
                n = n + RESN_W'(1);
            end else if (len != 3'd0 && !in_last) begin
                held_next[0]    = in_byte;
                held_count_next = 2'd1;
                seq_len_next    = len;
            end else begin
                r[n[1:0]].data     = REPL_BYTE;
                r[n[1:0]].replaced = 1'b1;
                n = n + RESN_W'(1);
            end
        end

        if (n != '0) begin
            r[n[1:0] - 2'd1].run_end    = 1'b1;
            r[n[1:0] - 2'd1].string_end = in_last;
        end

        // nothing stays held past the end of a string
        if (in_last) begin
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
        end

        for (int k = 0; k < MAX_RES; k++) begin
            group.item[k] = r[k];
        end
        group.n = n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
            held_reg       <= '{default: '0};
        end else if (accept) begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
            held_reg       <= held_next;
        end
    end

    a_held_len: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd0 |-> seq_len_reg > {1'b0, held_count_reg})
        else $error("held count not below sequence length");

    a_seq_len_range: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd0 |-> seq_len_reg >= 3'd2 && seq_len_reg <= 3'd4)
        else $error("held sequence length out of range");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_last |=> held_count_reg == 2'd0)
        else $error("bytes still held after end of string");

endmodule

### rtl/core/utf8s_queue.sv
module utf8s_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  utf8s_pkg::res_group_t group,
    output logic                  room,
    output logic                  out_valid,
    input  logic                  out_ready,
    output utf8s_pkg::res_t       out_item
);
    import utf8s_pkg::*;

    res_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [RESN_W-1:0] push_n;
    logic              pop;

    assign push_n    = push ? group.n : '0;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];
    // a full group must always fit
    assign room      = (count_reg <= QCNT_W'(QDEPTH - MAX_RES));

    assign count_next = count_reg + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_n);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (RESN_W'(k) < push_n) begin
                mem[wr_ptr_reg + QPTR_W'(k)] <= group.item[k];
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> room)
        else $error("word taken without room for its results");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + QCNT_W'($past(push_n)))
        else $error("queue count lost track of pushed results");

endmodule

### rtl/core/utf8_sanitizer_core.sv
// UTF-8 sanitizer core.
// Slave channel s_*: one raw byte per word, s_tlast on the final byte of a
// string. Master channel m_*: one repaired byte per word; m_tuser[0] marks a
// byte replaced by '?', m_tuser[1] marks the last result made by an input
// byte, m_tlast marks the final result of the string.
// Lead bytes and their continuations are held until the sequence completes
// and then leave unchanged; broken or cut-off sequences and stray bytes
// leave as '?'. Output byte count equals input byte count.
// A result is written into the result queue and reaches m_tdata from its head.
// Throughput: one input byte per cycle, one result per cycle; a byte may
// release up to four results, which drain through an eight-entry result
// queue. s_tready is low while more than four results wait, so a stalled
// receiver backs up into the slave side without loss.
// Reset (aresetn low, synchronous) empties the queue and drops held bytes.
module utf8_sanitizer_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] out_replaced, [1] run_end
    output logic       m_tlast    // string_end
);
    import utf8s_pkg::*;

    logic       accept;
    res_group_t group;
    res_t       head;

    assign accept = s_tvalid && s_tready;

    utf8s_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .group   (group)
    );

    utf8s_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .group     (group),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (head)
    );

    assign m_tdata = head.data;
    assign m_tuser = {head.run_end, head.replaced};
    assign m_tlast = head.string_end;

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          NUM_DIR     = 25;
    localparam int          DRAIN_WAIT  = 16;
    localparam int          STALL_LEN   = 300;

    localparam logic [7:0] QMARK = 8'h3F;
    localparam logic [1:0] CONT  = 2'b10;
    localparam logic [2:0] LEAD2 = 3'b110;
    localparam logic [3:0] LEAD3 = 4'b1110;
    localparam logic [4:0] LEAD4 = 5'b11110;

    typedef struct packed {
        logic [7:0] data;
        logic       replaced;
        logic       run_end;
        logic       string_end;
    } san_byte_t;

    typedef struct packed {
        logic [7:0] in_b;
        logic       last;
        logic       typed;
        san_byte_t  res;
    } dir_row_t;

    // typed rows all start with nothing held
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
        '{8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b0, 1'b1, 1'b1}},
        '{8'h80, 1'b0, 1'b1, '{QMARK, 1'b1, 1'b1, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{QMARK, 1'b1, 1'b1, 1'b0}},
        '{8'hF8, 1'b1, 1'b1, '{QMARK, 1'b1, 1'b1, 1'b1}},
        '{8'hC3, 1'b0, 1'b0, '0},
        '{8'hA9, 1'b0, 1'b0, '0},
        '{8'hE2, 1'b0, 1'b0, '0},
        '{8'h82, 1'b0, 1'b0, '0},
        '{8'hAC, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'h9F, 1'b0, 1'b0, '0},
        '{8'h98, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b0, '0},
        '{8'hE2, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b0, 1'b0, '0},
        '{8'h9F, 1'b1, 1'b0, '0},
        '{8'hDF, 1'b1, 1'b1, '{QMARK, 1'b1, 1'b1, 1'b1}},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'hE0, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, '0},
        '{8'hC2, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b1, 1'b0, '0}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    // sanitizer state as the predictor sees it
    logic [7:0]  held_q [3];
    logic [1:0]  held_n;
    logic [2:0]  need_len;
    san_byte_t   step_res [4];
    int          step_n;

    san_byte_t   pending_bytes [$];
    int          mismatches = 0;
    int          sent_words;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          long_stall_req = 1'b0;
    int unsigned cycle_cnt = 0;

    utf8_sanitizer_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void add_res(input logic [7:0] d, input logic repl);
        if (step_n < 4) begin
            step_res[step_n] = '{d, repl, 1'b0, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void release_held(input logic repl);
        for (int k = 0; k < held_n; k++) begin
            add_res(repl ? QMARK : held_q[k], repl);
        end
        held_q   = '{8'h00, 8'h00, 8'h00};
        held_n   = 2'd0;
        need_len = 3'd0;
    endfunction

    // work out the words one input byte releases, into step_res
    function automatic void sanitize_byte(input logic [7:0] b, input logic last);
        logic       is_cont;
        logic       fresh;
        logic [2:0] len;
        is_cont = (b[7:6] == CONT);
        fresh   = 1'b1;
        step_n  = 0;
        if (b[7:5] == LEAD2) begin
            len = 3'd2;
        end else if (b[7:4] == LEAD3) begin
            len = 3'd3;
        end else if (b[7:3] == LEAD4) begin
            len = 3'd4;
        end else begin
            len = 3'd0;
        end
        if (held_n != 2'd0) begin
            if (is_cont) begin
                fresh = 1'b0;
                if (int'(held_n) + 1 >= int'(need_len)) begin
                    release_held(1'b0);
                    add_res(b, 1'b0);
                end else if (last) begin
                    release_held(1'b1);
                    add_res(QMARK, 1'b1);
                end else if (held_n < 2'd3) begin
                    held_q[held_n] = b;
                    held_n = held_n + 2'd1;
                end
            end else begin
                release_held(1'b1);
            end
        end
        if (fresh) begin
            if (!b[7]) begin
                add_res(b, 1'b0);
            end else if (len != 3'd0 && !last) begin
                held_q[0] = b;
                held_n    = 2'd1;
                need_len  = len;
            end else begin
                add_res(QMARK, 1'b1);
            end
        end
        if (step_n > 0) begin
            step_res[step_n-1].run_end    = 1'b1;
            step_res[step_n-1].string_end = last;
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last, input logic typed,
                             input san_byte_t typed_res);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sanitize_byte(b, last);
        if (typed) begin
            pending_bytes = {pending_bytes, typed_res};
        end else begin
            for (int k = 0; k < step_n; k++) pending_bytes = {pending_bytes, step_res[k]};
        end
        sent_words++;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // mostly well-formed characters, some cut short, some stray bytes
    task automatic send_random_string();
        logic [7:0] str [$];
        int         n_chars;
        int         pick;
        int         len;
        int         n_cont;
        n_chars = $urandom_range(1, 10);
        for (int c = 0; c < n_chars; c++) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                str = {str, {1'b0, 7'($urandom)}};
            end else if (pick < 88) begin
                if (pick < 50) begin
                    len = 2;
                end else if (pick < 65) begin
                    len = 3;
                end else if (pick < 80) begin
                    len = 4;
                end else begin
                    len = $urandom_range(2, 4);
                end
                case (len)
                    2: str = {str, {LEAD2, 5'($urandom)}};
                    3: str = {str, {LEAD3, 4'($urandom)}};
                    default: str = {str, {LEAD4, 3'($urandom)}};
                endcase
                n_cont = (pick < 80) ? len - 1 : $urandom_range(0, len - 2);
                repeat (n_cont) str = {str, {CONT, 6'($urandom)}};
            end else if (pick < 94) begin
                str = {str, {CONT, 6'($urandom)}};
            end else begin
                str = {str, 8'($urandom)};
            end
        end
        foreach (str[i]) send_word(str[i], i == str.size() - 1, 1'b0, '0);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge aclk);
    endtask

    initial begin : rx_side
        int hold_left;
        bit stall_seen;
        hold_left  = 0;
        stall_seen = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_stall_req && !stall_seen) begin
                stall_seen = 1'b1;
                hold_left  = STALL_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_out
        san_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: data %02h user %b last %b",
                             m_tdata, m_tuser, m_tlast);
                end
            end else begin
                want = pending_bytes.pop_front();
                if (want.data !== m_tdata || want.replaced !== m_tuser[0] ||
                    want.run_end !== m_tuser[1] || want.string_end !== m_tlast) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch: expected data %02h repl %b run_end %b end %b,",
                                  " got %02h %b %b %b"},
                                 want.data, want.replaced, want.run_end, want.string_end,
                                 m_tdata, m_tuser[0], m_tuser[1], m_tlast);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        sent_words     = 0;
        held_q         = '{8'h00, 8'h00, 8'h00};
        held_n         = 2'd0;
        need_len       = 3'd0;
        step_n         = 0;
        tx_idle_pct    = 15;
        rx_idle_pct    = 55;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < NUM_DIR; r++) begin
            send_word(DIR_ROWS[r].in_b, DIR_ROWS[r].last, DIR_ROWS[r].typed, DIR_ROWS[r].res);
        end
        while (sent_words < 185) send_random_string();

        // hold the sender until the block has drained
        wait_drained();
        tx_idle_pct = 55;
        rx_idle_pct = 15;
        while (sent_words < 340) send_random_string();

        // back-to-back words into a receiver that stops for a long stretch
        tx_idle_pct    = 0;
        rx_idle_pct    = 0;
        long_stall_req = 1'b1;
        while (sent_words < 465) send_random_string();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
